@@ rtl/core/lbrd_pkg.sv @@
// Package for the logger binary record decoder: word kind codes, decode constants
// and the result item type. It has no dependencies.
package lbrd_pkg;

    typedef enum logic [1:0] {
        KIND_SKIP = 2'd0,
        KIND_HIGH = 2'd1,
        KIND_LOW  = 2'd2
    } word_kind_t;

    localparam int unsigned VALUE_COUNT_W = 7;
    localparam int unsigned MANTISSA_W    = 18;
    localparam int unsigned MAG_W         = 17;
    localparam int unsigned DP_W          = 3;
    localparam int unsigned OUT_DATA_W    = 24;

    // Magnitudes that mark a missing value when negative with exponent zero.
    localparam logic [MAG_W-1:0] LOW_SENTINEL_MAG  = 17'd6999;
    localparam logic [MAG_W-1:0] HIGH_SENTINEL_MAG = 17'd99999;

    // The first highest exponent that counts as invalid.
    localparam logic [DP_W-1:0] FIRST_BAD_EXP = 3'd6;

    typedef struct packed {
        logic                  missing;
        logic [DP_W-1:0]       decimal_places;
        logic [MANTISSA_W-1:0] mantissa;
    } out_item_t;

endpackage

@@ rtl/core/logger_binary_record_decoder_core.sv @@
// Logger binary record decoder: byte stream in, decoded value stream out.
// Depends on lbrd_pkg for word kinds, constants and the result item type.
//
// Usage:
//   s_tdata[7:0] carries one record byte per item and s_tlast marks the final
//   byte of a record. Each two-byte low-resolution word or valid four-byte
//   high-resolution word yields one item on the m_ side, whose m_tlast marks
//   the clamped value_count-th value of the record. cfg_data sets
//   value_count and is always accepted; write it only while the block is idle.
//   Each decoded value is registered in the result register before it leaves.
//   Throughput: one byte per cycle while the output is not stalled. At record
//   end the block inserts missing values up to the clamped value_count, one
//   per cycle while the output takes them, and decodes no byte meanwhile.
//   A one-item input buffer keeps s_tready a plain register output; it drops
//   while that buffer holds an item, which happens when the stalled output
//   cannot take a byte or while record-end padding is under way.
//   When m_tready is low the result register holds its item and the decoder
//   waits; nothing is lost.
//   Reset clears all word state and sets value_count to 1.
module logger_binary_record_decoder_core #(
    parameter int unsigned MAX_VALUES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_record
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [17:0] mantissa, [20:18] decimal_places, [21] missing
    output logic        m_tlast,   // last_value
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data   // value_count
);

    localparam int unsigned CW = $clog2(MAX_VALUES + 1);

    logic [lbrd_pkg::VALUE_COUNT_W-1:0] value_count_reg;
    logic [CW-1:0]                      eff_count;

    logic                   skid_valid_reg;
    logic [7:0]             skid_data_reg;
    logic                   skid_last_reg;

    logic [1:0]             phase_reg, phase_next;
    lbrd_pkg::word_kind_t   kind_reg, kind_next;
    logic [23:0]            held_reg, held_next;
    logic [CW-1:0]          emitted_reg, emitted_next;
    logic                   pad_reg, pad_next;

    logic                   out_valid_reg, out_valid_next;
    lbrd_pkg::out_item_t    out_item_reg, out_item_next;
    logic                   out_last_reg, out_last_next;

    logic                   in_acc;
    logic                   head_valid;
    logic [7:0]             head_byte;
    logic                   head_last;
    logic                   out_free;
    logic                   process;
    logic                   active;

    logic                      dec_emit;
    logic                      dec_neg;
    logic [lbrd_pkg::MAG_W-1:0] dec_mag;
    logic [lbrd_pkg::DP_W-1:0]  dec_exp;
    logic                      dec_miss;
    logic [31:0]               hi_word;
    logic [15:0]               lo_word;
    logic [CW:0]               emitted_inc;
    logic                      is_last;
    logic [lbrd_pkg::MANTISSA_W-1:0] signed_mag;

    // Effective count, clamped to 1..MAX_VALUES.
    always_comb
    begin
        if (value_count_reg == '0)
        begin
            eff_count = CW'(1);
        end
        else if (32'(value_count_reg) > MAX_VALUES)
        begin
            eff_count = CW'(MAX_VALUES);
        end
        else
        begin
            eff_count = CW'(value_count_reg);
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign in_acc    = s_tvalid && s_tready;

    assign head_valid = skid_valid_reg || in_acc;
    assign head_byte  = skid_valid_reg ? skid_data_reg : s_tdata;
    assign head_last  = skid_valid_reg ? skid_last_reg : s_tlast;

    assign out_free = !out_valid_reg || m_tready;
    assign process  = head_valid && out_free && !pad_reg;
    assign active   = emitted_reg < eff_count;

    assign hi_word = {held_reg, head_byte};
    assign lo_word = {held_reg[7:0], head_byte};

    assign emitted_inc = {1'b0, emitted_reg} + 1'b1;
    assign is_last     = emitted_inc == {1'b0, eff_count};

    // Word decode for the byte at the head of the input.
    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        held_next  = held_reg;
        dec_emit   = 1'b0;
        dec_neg    = 1'b0;
        dec_mag    = '0;
        dec_exp    = '0;
        dec_miss   = 1'b0;
        if (active)
        begin
            priority if (phase_reg == 2'd0)
            begin
                if ((head_byte & 8'h1c) == 8'h1c)
                begin
                    if ((head_byte & 8'hfc) == 8'hfc || head_byte == 8'h7f)
                    begin
                        kind_next  = lbrd_pkg::KIND_SKIP;
                        phase_next = 2'd1;
                    end
                    else if ((head_byte & 8'h3c) == 8'h1c)
                    begin
                        kind_next  = lbrd_pkg::KIND_HIGH;
                        held_next  = {16'h0000, head_byte};
                        phase_next = 2'd1;
                    end
                end
                else
                begin
                    kind_next  = lbrd_pkg::KIND_LOW;
                    held_next  = {16'h0000, head_byte};
                    phase_next = 2'd1;
                end
            end
            else if (phase_reg == 2'd1 && kind_reg == lbrd_pkg::KIND_LOW)
            begin
                dec_emit   = 1'b1;
                dec_neg    = lo_word[15];
                dec_exp    = {1'b0, lo_word[14:13]};
                dec_mag    = {4'h0, lo_word[12:0]};
                dec_miss   = lo_word[15] && lo_word[14:13] == 2'd0
                             && {4'h0, lo_word[12:0]} == lbrd_pkg::LOW_SENTINEL_MAG;
                phase_next = 2'd0;
            end
            else if (kind_reg == lbrd_pkg::KIND_HIGH && phase_reg != 2'd3)
            begin
                held_next  = {held_reg[15:0], head_byte};
                phase_next = phase_reg + 2'd1;
            end
            else if (kind_reg == lbrd_pkg::KIND_HIGH)
            begin
                // The third byte must look like 0x3C..0x3F for the word to count.
                dec_emit   = hi_word[15:10] == 6'b001111;
                dec_neg    = hi_word[30];
                dec_exp    = {hi_word[25:24], hi_word[31]};
                dec_mag    = {hi_word[8], hi_word[23:16], hi_word[7:0]};
                dec_miss   = (hi_word[30] && dec_exp == '0
                              && dec_mag == lbrd_pkg::HIGH_SENTINEL_MAG)
                             || dec_exp >= lbrd_pkg::FIRST_BAD_EXP;
                phase_next = 2'd0;
            end
            else
            begin
                phase_next = 2'd0;
            end
        end
    end

    assign signed_mag = dec_neg ? (18'd0 - {1'b0, dec_mag}) : {1'b0, dec_mag};

    // Sequencing of decoded values, record-end padding and the result register.
    always_comb
    begin
        emitted_next   = emitted_reg;
        pad_next       = pad_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_item_next  = out_item_reg;
        out_last_next  = out_last_reg;

        if (pad_reg)
        begin
            if (out_free)
            begin
                out_valid_next               = 1'b1;
                out_item_next.missing        = 1'b1;
                out_item_next.decimal_places = '0;
                out_item_next.mantissa       = '0;
                out_last_next                = is_last;
                if (is_last)
                begin
                    emitted_next = '0;
                    pad_next     = 1'b0;
                end
                else
                begin
                    emitted_next = emitted_inc[CW-1:0];
                end
            end
        end
        else if (process)
        begin
            if (dec_emit)
            begin
                out_valid_next               = 1'b1;
                out_item_next.missing        = dec_miss;
                out_item_next.decimal_places = dec_miss ? '0 : dec_exp;
                out_item_next.mantissa       = dec_miss ? '0 : signed_mag;
                out_last_next                = is_last;
                emitted_next                 = emitted_inc[CW-1:0];
            end
            if (head_last)
            begin
                // Pad only while the record still lacks values.
                if ((dec_emit ? emitted_inc[CW-1:0] : emitted_reg) < eff_count)
                begin
                    pad_next = 1'b1;
                end
                else
                begin
                    emitted_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_count_reg <= 7'd1;
            skid_valid_reg  <= 1'b0;
            phase_reg       <= 2'd0;
            kind_reg        <= lbrd_pkg::KIND_SKIP;
            held_reg        <= '0;
            emitted_reg     <= '0;
            pad_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                value_count_reg <= cfg_data;
            end
            skid_valid_reg <= skid_valid_reg ? !process : (in_acc && !process);
            if (process)
            begin
                if (head_last)
                begin
                    phase_reg <= 2'd0;
                    kind_reg  <= lbrd_pkg::KIND_SKIP;
                    held_reg  <= '0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    kind_reg  <= kind_next;
                    held_reg  <= held_next;
                end
            end
            emitted_reg   <= emitted_next;
            pad_reg       <= pad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && !process)
        begin
            skid_data_reg <= s_tdata;
            skid_last_reg <= s_tlast;
        end
        out_item_reg <= out_item_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_item_reg};
    assign m_tlast  = out_last_reg;

endmodule
